// File: rtl/owm_pkg.sv
`timescale 1ns / 1ps

package owm_pkg;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 8;

  // Operation codes of an input item
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_RESET      = 3'd1;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
  localparam logic [2:0] OP_READ_BYTE  = 3'd3;
  localparam logic [2:0] OP_WRITE_BIT  = 3'd4;
  localparam logic [2:0] OP_READ_BIT   = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_RECOVERY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_RESET_LOW      = 10'd480;
  localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT  = 10'd60;
  localparam logic [CFG_W-1:0] RST_RESET_TAIL     = 10'd240;
  localparam logic [CFG_W-1:0] RST_WRITE_ONE_LOW  = 10'd15;
  localparam logic [CFG_W-1:0] RST_WRITE_ZERO_LOW = 10'd60;
  localparam logic [CFG_W-1:0] RST_WRITE_RECOVERY = 10'd30;
  localparam logic [CFG_W-1:0] RST_READ_LOW       = 10'd15;
  localparam logic [CFG_W-1:0] RST_READ_TAIL      = 10'd60;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } out_item_t;

  // Classified tick handed from the front to the engine
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] init_shift;
    logic       line_level;
  } cmd_t;

endpackage

// File: rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps
// A tick's result is held in the front command queue, then the engine step writes it into the
// result queue, from which the out_ side reads it; a full result queue stalls the engine.
// Throughput: one tick per cycle while the result queue is not full, set by the engine step.
// Both sides have two-entry queues, so either side may stall without a bubble.
// Reset (rst_n low, synchronous): queues empty, engine idle, registers at defaults.
module one_wire_bus_master import owm_pkg::*; #(
  parameter int TIMER_WIDTH = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd_data;

  owm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data)
  );

  owm_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: rtl/owm_front.sv
`timescale 1ns / 1ps

module owm_front import owm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_pop,
  output cmd_t     cmd_data
);

  cmd_t       cls;
  cmd_t       ent_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push_ok, pop_ok;

  // Fold unused op codes into plain ticks and prepare the shift register load
  always_comb begin
    cls.line_level = in_data.line_level;
    cls.op         = in_data.op;
    cls.init_shift = 8'h00;
    case (in_data.op)
      OP_WRITE_BYTE: cls.init_shift = in_data.data_byte;
      OP_WRITE_BIT:  cls.init_shift = {7'b0, in_data.data_byte[0]};
      OP_RESET, OP_READ_BYTE, OP_READ_BIT, OP_TICK: cls.init_shift = 8'h00;
      default: cls.op = OP_TICK;
    endcase
  end

  assign in_full   = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd_data  = ent_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) count_nxt = count_r + 2'd1;
    else if (pop_ok && !push_ok) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) ent_r[wr_ptr_r] <= cls;
  end

endmodule

// File: rtl/owm_engine.sv
`timescale 1ns / 1ps

module owm_engine import owm_pkg::*; #(
  parameter int TIMER_WIDTH = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  cmd_t                 cmd_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data
);

  localparam int EW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam logic [EW-1:0] TMAX = EW'((1 << TIMER_WIDTH) - 1);

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_SAMP = 10'b00_0000_1000,
    PH_RST_TAIL = 10'b00_0001_0000,
    PH_WR_LOW   = 10'b00_0010_0000,
    PH_WR_REC   = 10'b00_0100_0000,
    PH_RD_LOW   = 10'b00_1000_0000,
    PH_RD_SAMP  = 10'b01_0000_0000,
    PH_RD_TAIL  = 10'b10_0000_0000
  } phase_t;

  logic [CFG_W-1:0] cfg_r [NUM_REGS];

  phase_t                 phase_r, phase_nxt, cur_phase, next_ph;
  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt, cur_tick, len;
  logic [7:0]             shift_r, shift_nxt;
  logic [3:0]             bit_r, bit_nxt, slots;
  logic [2:0]             kind_r, kind_nxt;
  logic                   pres_r, pres_nxt;
  logic                   last, busy, done, pull;
  logic [TIMER_WIDTH:0]   tick_inc;
  out_item_t              res;

  out_item_t  q_r [2];
  logic [1:0] q_count_r, q_count_nxt;
  logic       q_wr_r, q_rd_r, q_full, q_pop_ok;

  // Zero means one tick; clamp to the timer range
  function automatic logic [TIMER_WIDTH-1:0] eff_len(input logic [CFG_W-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x == '0) x = EW'(1);
    if (x > TMAX) x = TMAX;
    return x[TIMER_WIDTH-1:0];
  endfunction

  assign q_full  = (q_count_r == 2'd2);
  assign cmd_pop = cmd_valid && !q_full;

  always_comb begin
    cur_phase = phase_r;
    cur_tick  = tick_r;
    shift_nxt = shift_r;
    bit_nxt   = bit_r;
    kind_nxt  = kind_r;
    pres_nxt  = pres_r;

    // A command in idle starts at once; this tick is its first
    if (phase_r == PH_IDLE && cmd_data.op != OP_TICK) begin
      kind_nxt  = cmd_data.op;
      cur_tick  = '0;
      bit_nxt   = 4'd0;
      shift_nxt = cmd_data.init_shift;
      case (cmd_data.op)
        OP_RESET:                    cur_phase = PH_RST_LOW;
        OP_WRITE_BYTE, OP_WRITE_BIT: cur_phase = PH_WR_LOW;
        default:                     cur_phase = PH_RD_LOW;
      endcase
    end

    slots = (kind_nxt == OP_WRITE_BYTE || kind_nxt == OP_READ_BYTE) ? 4'd8 : 4'd1;

    case (cur_phase)
      PH_RST_LOW:  len = eff_len(cfg_r[REG_RESET_LOW]);
      PH_RST_WAIT: len = eff_len(cfg_r[REG_PRESENCE_WAIT]);
      PH_RST_TAIL: len = eff_len(cfg_r[REG_RESET_TAIL]);
      PH_WR_LOW:   len = shift_nxt[0] ? eff_len(cfg_r[REG_WRITE_ONE_LOW])
                                      : eff_len(cfg_r[REG_WRITE_ZERO_LOW]);
      PH_WR_REC:   len = eff_len(cfg_r[REG_WRITE_RECOVERY]);
      PH_RD_LOW:   len = eff_len(cfg_r[REG_READ_LOW]);
      PH_RD_TAIL:  len = eff_len(cfg_r[REG_READ_TAIL]);
      default:     len = TIMER_WIDTH'(1);
    endcase

    tick_inc = {1'b0, cur_tick} + (TIMER_WIDTH+1)'(1);
    last     = (tick_inc >= {1'b0, len});
    busy     = (cur_phase != PH_IDLE);
    pull     = 1'b0;
    next_ph  = PH_IDLE;

    case (cur_phase)
      PH_RST_LOW: begin
        pull    = 1'b1;
        next_ph = PH_RST_WAIT;
      end
      PH_RST_WAIT: next_ph = PH_RST_SAMP;
      PH_RST_SAMP: begin
        pres_nxt = !cmd_data.line_level;
        next_ph  = PH_RST_TAIL;
      end
      PH_RST_TAIL: next_ph = PH_IDLE;
      PH_WR_LOW: begin
        pull    = 1'b1;
        next_ph = PH_WR_REC;
      end
      PH_WR_REC: begin
        if (last) begin
          shift_nxt = {1'b0, shift_nxt[7:1]};
          bit_nxt   = bit_nxt + 4'd1;
        end
        next_ph = (bit_nxt >= slots) ? PH_IDLE : PH_WR_LOW;
      end
      PH_RD_LOW: begin
        pull    = 1'b1;
        next_ph = PH_RD_SAMP;
      end
      PH_RD_SAMP: begin
        if (cmd_data.line_level) shift_nxt[bit_nxt[2:0]] = 1'b1;
        next_ph = PH_RD_TAIL;
      end
      PH_RD_TAIL: begin
        if (last) bit_nxt = bit_nxt + 4'd1;
        next_ph = (bit_nxt >= slots) ? PH_IDLE : PH_RD_LOW;
      end
      default: next_ph = PH_IDLE;
    endcase

    phase_nxt = cur_phase;
    tick_nxt  = cur_tick;
    done      = 1'b0;
    if (busy) begin
      if (last) begin
        tick_nxt  = '0;
        phase_nxt = next_ph;
        done      = (next_ph == PH_IDLE);
      end else begin
        tick_nxt = tick_inc[TIMER_WIDTH-1:0];
      end
    end

    res.pull_low  = pull;
    res.busy_res  = busy;
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = (kind_nxt == OP_READ_BYTE || kind_nxt == OP_READ_BIT) ? shift_nxt : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      shift_r <= 8'h00;
      bit_r   <= 4'd0;
      kind_r  <= OP_TICK;
      pres_r  <= 1'b0;
    end else if (cmd_pop) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      bit_r   <= bit_nxt;
      kind_r  <= kind_nxt;
      pres_r  <= pres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_RESET_LOW]      <= RST_RESET_LOW;
      cfg_r[REG_PRESENCE_WAIT]  <= RST_PRESENCE_WAIT;
      cfg_r[REG_RESET_TAIL]     <= RST_RESET_TAIL;
      cfg_r[REG_WRITE_ONE_LOW]  <= RST_WRITE_ONE_LOW;
      cfg_r[REG_WRITE_ZERO_LOW] <= RST_WRITE_ZERO_LOW;
      cfg_r[REG_WRITE_RECOVERY] <= RST_WRITE_RECOVERY;
      cfg_r[REG_READ_LOW]       <= RST_READ_LOW;
      cfg_r[REG_READ_TAIL]      <= RST_READ_TAIL;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // Result queue
  assign out_empty = (q_count_r == 2'd0);
  assign out_data  = q_r[q_rd_r];
  assign q_pop_ok  = out_pop && !out_empty;

  always_comb begin
    q_count_nxt = q_count_r;
    if (cmd_pop && !q_pop_ok) q_count_nxt = q_count_r + 2'd1;
    else if (q_pop_ok && !cmd_pop) q_count_nxt = q_count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_count_r <= 2'd0;
      q_wr_r    <= 1'b0;
      q_rd_r    <= 1'b0;
    end else begin
      q_count_r <= q_count_nxt;
      if (cmd_pop)  q_wr_r <= ~q_wr_r;
      if (q_pop_ok) q_rd_r <= ~q_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) q_r[q_wr_r] <= res;
  end

endmodule

// File: tb/sv/one_wire_bus_master_tb.sv
`timescale 1ns / 1ps

module one_wire_bus_master_tb;
  import owm_pkg::*;

  // op codes outside the command set, decoded as plain ticks
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef logic [CFG_W-1:0] reg_set_t [NUM_REGS];

  typedef enum logic [3:0] {
    BP_IDLE, BP_RST_LOW, BP_RST_WAIT, BP_RST_SAMP, BP_RST_TAIL,
    BP_WR_LOW, BP_WR_REC, BP_RD_LOW, BP_RD_SAMP, BP_RD_TAIL
  } bus_phase_t;

  function automatic reg_set_t default_regs();
    reg_set_t v;
    v[REG_RESET_LOW]      = RST_RESET_LOW;
    v[REG_PRESENCE_WAIT]  = RST_PRESENCE_WAIT;
    v[REG_RESET_TAIL]     = RST_RESET_TAIL;
    v[REG_WRITE_ONE_LOW]  = RST_WRITE_ONE_LOW;
    v[REG_WRITE_ZERO_LOW] = RST_WRITE_ZERO_LOW;
    v[REG_WRITE_RECOVERY] = RST_WRITE_RECOVERY;
    v[REG_READ_LOW]       = RST_READ_LOW;
    v[REG_READ_TAIL]      = RST_READ_TAIL;
    return v;
  endfunction

  class tick_scoreboard;
    reg_set_t    regs;
    bus_phase_t  phase;
    int unsigned ticks_in_phase;
    logic [7:0]  shifter;
    logic [3:0]  slots_done;
    logic [2:0]  cmd;
    logic        presence_seen;
    out_item_t   expected_ticks[$];
    int unsigned n_cmds, n_checked, errors;

    function new();
      regs = default_regs();
      phase = BP_IDLE;
      ticks_in_phase = 0;
      shifter = '0;
      slots_done = '0;
      cmd = OP_TICK;
      presence_seen = 1'b0;
      n_cmds = 0;
      n_checked = 0;
      errors = 0;
    endfunction

    function void load(reg_set_t v);
      regs = v;
    endfunction

    function bit idle();
      return phase == BP_IDLE;
    endfunction

    function int unsigned pending();
      return expected_ticks.size();
    endfunction

    // a zero length still lasts one tick
    function int unsigned span(logic [CFG_IDX_W-1:0] idx);
      return (regs[idx] == '0) ? 1 : regs[idx];
    endfunction

    function int unsigned phase_span();
      case (phase)
        BP_RST_LOW:  return span(REG_RESET_LOW);
        BP_RST_WAIT: return span(REG_PRESENCE_WAIT);
        BP_RST_TAIL: return span(REG_RESET_TAIL);
        BP_WR_LOW:   return shifter[0] ? span(REG_WRITE_ONE_LOW) : span(REG_WRITE_ZERO_LOW);
        BP_WR_REC:   return span(REG_WRITE_RECOVERY);
        BP_RD_LOW:   return span(REG_READ_LOW);
        BP_RD_TAIL:  return span(REG_READ_TAIL);
        default:     return 1;
      endcase
    endfunction

    function int unsigned slot_count();
      return (cmd == OP_WRITE_BYTE || cmd == OP_READ_BYTE) ? 8 : 1;
    endfunction

    function void note_tick(in_item_t it);
      out_item_t  r;
      bus_phase_t nxt;
      bit         last;
      r = '0;
      nxt = BP_IDLE;
      if (phase == BP_IDLE && it.op >= OP_RESET && it.op <= OP_READ_BIT) begin
        cmd = it.op;
        ticks_in_phase = 0;
        slots_done = '0;
        n_cmds++;
        case (it.op)
          OP_RESET: begin
            phase = BP_RST_LOW;
            shifter = '0;
          end
          OP_WRITE_BYTE: begin
            phase = BP_WR_LOW;
            shifter = it.data_byte;
          end
          OP_WRITE_BIT: begin
            phase = BP_WR_LOW;
            shifter = {7'b0, it.data_byte[0]};
          end
          default: begin
            phase = BP_RD_LOW;
            shifter = '0;
          end
        endcase
      end
      if (phase != BP_IDLE) begin
        r.busy_res = 1'b1;
        last = (ticks_in_phase + 1 >= phase_span());
        case (phase)
          BP_RST_LOW: begin
            r.pull_low = 1'b1;
            nxt = BP_RST_WAIT;
          end
          BP_RST_WAIT: nxt = BP_RST_SAMP;
          BP_RST_SAMP: begin
            presence_seen = ~it.line_level;
            nxt = BP_RST_TAIL;
          end
          BP_RST_TAIL: nxt = BP_IDLE;
          BP_WR_LOW: begin
            r.pull_low = 1'b1;
            nxt = BP_WR_REC;
          end
          BP_WR_REC: begin
            if (last) begin
              shifter = shifter >> 1;
              slots_done++;
            end
            nxt = (slots_done >= slot_count()) ? BP_IDLE : BP_WR_LOW;
          end
          BP_RD_LOW: begin
            r.pull_low = 1'b1;
            nxt = BP_RD_SAMP;
          end
          BP_RD_SAMP: begin
            if (it.line_level) shifter[slots_done[2:0]] = 1'b1;
            nxt = BP_RD_TAIL;
          end
          default: begin
            if (last) slots_done++;
            nxt = (slots_done >= slot_count()) ? BP_IDLE : BP_RD_LOW;
          end
        endcase
        if (last) begin
          ticks_in_phase = 0;
          phase = nxt;
          if (nxt == BP_IDLE) r.done_res = 1'b1;
        end else begin
          ticks_in_phase++;
        end
      end
      r.presence = presence_seen;
      r.read_data = (cmd == OP_READ_BYTE || cmd == OP_READ_BIT) ? shifter : 8'h00;
      expected_ticks.push_back(r);
    endfunction

    function void check_tick(out_item_t got);
      out_item_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result pull=%b busy=%b done=%b pres=%b data=%h",
                   got.pull_low, got.busy_res, got.done_res, got.presence, got.read_data);
        return;
      end
      want = expected_ticks.pop_front();
      n_checked++;
      if (got.pull_low !== want.pull_low || got.busy_res !== want.busy_res ||
          got.done_res !== want.done_res || got.presence !== want.presence ||
          got.read_data !== want.read_data) begin
        errors++;
        if (errors <= 10) begin
          $write("result %0d: expected pull=%b busy=%b done=%b pres=%b data=%h, ", n_checked,
                 want.pull_low, want.busy_res, want.done_res, want.presence, want.read_data);
          $display("got pull=%b busy=%b done=%b pres=%b data=%h", got.pull_low, got.busy_res,
                   got.done_res, got.presence, got.read_data);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  in_item_t             in_data;
  logic                 out_empty;
  logic                 out_pop;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  tick_scoreboard sb;
  bit             gaps_on;
  bit             hold_req;
  int             hold_left;
  int unsigned    n_items;
  int unsigned    n_settings;

  one_wire_bus_master DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 60;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= !(gaps_on && $urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_tick(out_data);
  end

  function automatic in_item_t tick_item(logic [2:0] op, logic [7:0] data, logic lvl);
    in_item_t it;
    it.op = op;
    it.data_byte = data;
    it.line_level = lvl;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(input in_item_t it);
    while (gaps_on && $urandom_range(0, 99) < 24) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_tick(it);
    n_items++;
    @(negedge clk);
  endtask

  // keep ticking until the command in progress completes
  task automatic finish_command();
    while (!sb.idle())
      push_item(tick_item(3'($urandom_range(OP_TICK, OP_RSVD7)), rand_byte(),
                          1'($urandom)));
  endtask

  task automatic run_random(input int n);
    in_item_t it;
    repeat (n) begin
      if (sb.idle() && $urandom_range(0, 99) < 45)
        it.op = 3'($urandom_range(OP_RESET, OP_READ_BIT));
      else if ($urandom_range(0, 99) < 15)
        it.op = 3'($urandom_range(OP_TICK, OP_RSVD7));
      else
        it.op = OP_TICK;
      it.data_byte = rand_byte();
      it.line_level = 1'($urandom);
      push_item(it);
    end
    finish_command();
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_regs(input reg_set_t v);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= v[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    sb.load(v);
    n_settings++;
  endtask

  initial begin
    #400_000;
    $display("timeout with %0d results still pending", sb.pending());
    $display("[one_wire_bus_master] ERROR");
    $finish;
  end

  initial begin
    reg_set_t v;
    clk = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RESET_LOW;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    n_items = 0;
    n_settings = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero lengths: every phase lasts one tick, so commands are short
    foreach (v[i]) v[i] = '0;
    load_regs(v);
    push_item(tick_item(OP_TICK, 8'h00, 1'b0));
    push_item(tick_item(OP_RSVD7, 8'hFF, 1'b1));
    push_item(tick_item(OP_RSVD6, 8'h00, 1'b0));
    push_item(tick_item(OP_RESET, 8'hFF, 1'b1));
    push_item(tick_item(OP_WRITE_BYTE, 8'hFF, 1'b1));
    push_item(tick_item(OP_TICK, 8'h00, 1'b0));
    push_item(tick_item(OP_RESET, 8'h00, 1'b1));
    push_item(tick_item(OP_WRITE_BIT, 8'hFF, 1'b0));
    push_item(tick_item(OP_READ_BIT, 8'h00, 1'b0));
    push_item(tick_item(OP_READ_BIT, 8'h00, 1'b1));
    push_item(tick_item(OP_TICK, 8'h00, 1'b1));
    push_item(tick_item(OP_TICK, 8'h00, 1'b0));
    push_item(tick_item(OP_RESET, 8'h00, 1'b1));
    push_item(tick_item(OP_TICK, 8'h00, 1'b0));
    push_item(tick_item(OP_TICK, 8'h00, 1'b1));
    push_item(tick_item(OP_TICK, 8'h00, 1'b0));
    push_item(tick_item(OP_WRITE_BIT, 8'hFE, 1'b1));
    push_item(tick_item(OP_TICK, 8'h00, 1'b1));
    push_item(tick_item(OP_READ_BIT, 8'h00, 1'b0));
    push_item(tick_item(OP_TICK, 8'h00, 1'b0));
    push_item(tick_item(OP_TICK, 8'h00, 1'b0));
    push_item(tick_item(OP_READ_BYTE, 8'h00, 1'b0));
    finish_command();
    drain();

    // default lengths: one short write slot and one read slot
    load_regs(default_regs());
    push_item(tick_item(OP_WRITE_BIT, 8'h01, 1'b1));
    finish_command();
    push_item(tick_item(OP_READ_BIT, 8'h00, 1'b1));
    finish_command();
    drain();

    foreach (v[i]) v[i] = CFG_W'(1);
    load_regs(v);
    run_random(150);
    drain();

    // no idling on the sender while the receiver holds off: fill and stall
    foreach (v[i]) v[i] = CFG_W'($urandom_range(1, 6));
    load_regs(v);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    run_random(150);
    gaps_on = 1'b1;
    drain();

    foreach (v[i]) v[i] = CFG_W'($urandom_range(1, 24));
    v[$urandom_range(0, NUM_REGS - 1)] = '0;
    load_regs(v);
    run_random(150);
    drain();

    // long write-one low phase: drive the phase timer through its upper bits
    foreach (v[i]) v[i] = CFG_W'(1);
    v[REG_WRITE_ONE_LOW] = CFG_W'(400);
    load_regs(v);
    push_item(tick_item(OP_WRITE_BIT, 8'h01, 1'b1));
    finish_command();
    drain();

    $display("Covered %0d bus ticks and %0d commands over %0d timing settings", n_items,
             sb.n_cmds, n_settings);
    $display("(zero, one, default, random and long lengths); %0d results checked, %0d bad",
             sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[one_wire_bus_master] OK");
    end else begin
      $display("[one_wire_bus_master] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/owm_pkg.sv
rtl/owm_front.sv
rtl/owm_engine.sv
rtl/one_wire_bus_master.sv
tb/sv/one_wire_bus_master_tb.sv
